// ===== rtl/itemset_utility_evaluator_defines.svh =====
// assertion macros for the itemset utility evaluator
`ifndef ITEMSET_UTILITY_EVALUATOR_DEFINES_SVH
`define ITEMSET_UTILITY_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define IUE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iue assertion failed");
`define IUE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iue assertion failed");
`else
`define IUE_ASSERT_SAME(label, ante, cons)
`define IUE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/iue_pkg.sv =====
package iue_pkg;

    localparam int MAX_ITEMS   = 32;
    localparam int MAX_TRANS   = 1024;
    localparam int UTIL_BITS   = 16;

    localparam int ITEM_IDX_W  = $clog2(MAX_ITEMS);
    localparam int ITEM_CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int TRANS_IDX_W = $clog2(MAX_TRANS);
    localparam int ROW_CNT_W   = $clog2(MAX_TRANS + 1);
    localparam int GROUP_SIZE  = 8;
    localparam int GROUPS      = (MAX_ITEMS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PSUM_W      = UTIL_BITS + $clog2(GROUP_SIZE);
    localparam int ROWSUM_W    = UTIL_BITS + $clog2(MAX_ITEMS);
    localparam int SUM_W       = 32;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cmd_e;

    typedef enum logic [1:0] {
        CFG_ITEMS = 2'd0,
        CFG_TRANS = 2'd1,
        CFG_MIN   = 2'd2
    } cfg_idx_e;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PICK,
        ST_SCAN,
        ST_SUM,
        ST_DONE
    } state_e;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  trans_index;
        logic [4:0]  item_index;
        logic        present;
        logic [15:0] item_utility;
        logic [31:0] candidate_mask;
        logic        prune_enable;
    } request_t;

    typedef struct packed {
        logic [31:0] kept_mask;
        logic [31:0] utility_sum;
        logic        is_high_utility;
        logic        saturated;
    } result_t;

    typedef struct packed {
        logic                   en;
        logic [TRANS_IDX_W-1:0] addr;
        logic [MAX_ITEMS-1:0]   bit_en;
        logic [MAX_ITEMS-1:0]   pres;
        logic                   util_en;
        logic [ITEM_IDX_W-1:0]  lane;
        logic [UTIL_BITS-1:0]   util;
    } tbl_wr_t;

    typedef struct packed {
        logic                   en;
        logic [TRANS_IDX_W-1:0] addr;
    } tbl_rd_t;

    typedef struct packed {
        logic busy;
        logic valid;
    } add_stat_t;

    // ones in the low n item positions
    function automatic logic [MAX_ITEMS-1:0] item_mask(input logic [ITEM_CNT_W-1:0] n);
        logic [MAX_ITEMS-1:0] m;
        for (int b = 0; b < MAX_ITEMS; b++)
        begin
            m[b] = (ITEM_CNT_W'(b) < n);
        end
        return m;
    endfunction

endpackage

// ===== rtl/iue_table.sv =====
module iue_table (
    input  logic                            clk,
    input  iue_pkg::tbl_wr_t                wr,
    input  iue_pkg::tbl_rd_t                rd,
    output logic [iue_pkg::MAX_ITEMS-1:0]   rd_pres,
    output logic [iue_pkg::UTIL_BITS-1:0]   rd_util [iue_pkg::MAX_ITEMS]
);

    logic [iue_pkg::MAX_ITEMS-1:0] pres_mem [iue_pkg::MAX_TRANS];
    logic [iue_pkg::UTIL_BITS-1:0] util_mem [iue_pkg::MAX_TRANS][iue_pkg::MAX_ITEMS];

    // bit-enable write on presence rows
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            for (int b = 0; b < iue_pkg::MAX_ITEMS; b++)
            begin
                if (wr.bit_en[b])
                begin
                    pres_mem[wr.addr][b] <= wr.pres[b];
                end
            end
        end
        if (rd.en)
        begin
            rd_pres <= pres_mem[rd.addr];
        end
    end

    // lane write on utility rows, whole row read
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.util_en)
        begin
            util_mem[wr.addr][wr.lane] <= wr.util;
        end
        if (rd.en)
        begin
            rd_util <= util_mem[rd.addr];
        end
    end

endmodule

// ===== rtl/iue_adder.sv =====
module iue_adder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [iue_pkg::MAX_ITEMS-1:0]   mask,
    input  logic [iue_pkg::MAX_ITEMS-1:0]   pres,
    input  logic [iue_pkg::UTIL_BITS-1:0]   util [iue_pkg::MAX_ITEMS],
    output iue_pkg::add_stat_t              stat,
    output logic [iue_pkg::ROWSUM_W-1:0]    row_sum
);

    logic [iue_pkg::PSUM_W-1:0]   psum_next [iue_pkg::GROUPS];
    logic [iue_pkg::PSUM_W-1:0]   psum_reg  [iue_pkg::GROUPS];
    logic                         hit_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic [iue_pkg::ROWSUM_W-1:0] row_sum_next;
    logic [iue_pkg::ROWSUM_W-1:0] row_sum_reg;

    // first stage: partial sums of the selected lanes
    always_comb
    begin
        for (int g = 0; g < iue_pkg::GROUPS; g++)
        begin
            psum_next[g] = '0;
            for (int l = 0; l < iue_pkg::GROUP_SIZE; l++)
            begin
                if (g * iue_pkg::GROUP_SIZE + l < iue_pkg::MAX_ITEMS)
                begin
                    if (mask[g * iue_pkg::GROUP_SIZE + l])
                    begin
                        psum_next[g] = psum_next[g]
                            + iue_pkg::PSUM_W'(util[g * iue_pkg::GROUP_SIZE + l]);
                    end
                end
            end
        end
    end

    // second stage: row total, zero when the row lacks a kept item
    always_comb
    begin
        row_sum_next = '0;
        for (int g = 0; g < iue_pkg::GROUPS; g++)
        begin
            row_sum_next = row_sum_next + iue_pkg::ROWSUM_W'(psum_reg[g]);
        end
        if (!hit_reg)
        begin
            row_sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        psum_reg    <= psum_next;
        hit_reg     <= ((pres & mask) == mask);
        row_sum_reg <= row_sum_next;
    end

    assign row_sum    = row_sum_reg;
    assign stat.valid = v2_reg;
    assign stat.busy  = v1_reg | v2_reg;

endmodule

// ===== rtl/iue_ctrl.sv =====
module iue_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  iue_pkg::request_t                request,
    input  logic [iue_pkg::ITEM_CNT_W-1:0]   items_in_use,
    input  logic [iue_pkg::ROW_CNT_W-1:0]    transactions_in_use,
    input  logic [31:0]                      utility_floor,
    input  logic [iue_pkg::MAX_ITEMS-1:0]    rd_pres,
    input  iue_pkg::add_stat_t               add_stat,
    input  logic [iue_pkg::ROWSUM_W-1:0]     row_sum,
    output iue_pkg::tbl_wr_t                 wr,
    output iue_pkg::tbl_rd_t                 rd,
    output logic                             rd_valid,
    output logic [iue_pkg::MAX_ITEMS-1:0]    sum_mask,
    output logic                             busy,
    output logic                             done,
    output iue_pkg::result_t                 result
);

    iue_pkg::state_e state_reg, state_next;

    logic [iue_pkg::MAX_ITEMS-1:0]   mask_reg,  mask_next;
    logic [iue_pkg::MAX_ITEMS-1:0]   kept_reg,  kept_next;
    logic [iue_pkg::MAX_ITEMS-1:0]   need_reg,  need_next;
    logic                            started_reg, started_next;
    logic [iue_pkg::ITEM_IDX_W-1:0]  j_reg,     j_next;
    logic [iue_pkg::ROW_CNT_W-1:0]   addr_reg,  addr_next;
    logic [iue_pkg::ROW_CNT_W-1:0]   rows_reg,  rows_next;
    logic                            found_reg, found_next;
    logic [iue_pkg::SUM_W-1:0]       total_reg, total_next;
    logic                            sat_reg,   sat_next;
    logic                            rd_valid_reg, rd_valid_next;

    logic                            accept;
    logic                            issue;
    logic                            last_item;
    logic [iue_pkg::MAX_ITEMS-1:0]   j_bit;
    logic [iue_pkg::MAX_ITEMS-1:0]   kept_adv;
    logic                            pick_to_scan;
    logic                            scan_end;
    logic                            sum_end;
    logic [iue_pkg::ITEM_CNT_W-1:0]  n_items;
    logic [iue_pkg::SUM_W:0]         acc;

    assign accept    = start && (state_reg == iue_pkg::ST_IDLE);
    assign last_item = (j_reg == iue_pkg::ITEM_IDX_W'(iue_pkg::MAX_ITEMS - 1));
    assign j_bit     = iue_pkg::MAX_ITEMS'(1) << j_reg;
    assign n_items   = (items_in_use > iue_pkg::ITEM_CNT_W'(iue_pkg::MAX_ITEMS))
                       ? iue_pkg::ITEM_CNT_W'(iue_pkg::MAX_ITEMS) : items_in_use;
    assign issue     = ((state_reg == iue_pkg::ST_SCAN) ||
                        (state_reg == iue_pkg::ST_SUM && mask_reg != '0))
                       && (addr_reg < rows_reg);
    assign pick_to_scan = mask_reg[j_reg] && started_reg;
    assign scan_end  = (addr_reg >= rows_reg) && !rd_valid_reg;
    assign sum_end   = (mask_reg == '0) || (scan_end && !add_stat.busy);
    assign acc       = {1'b0, total_reg} + (iue_pkg::SUM_W + 1)'(row_sum);

    // kept set after the item under test is decided
    always_comb
    begin
        kept_adv = kept_reg;
        if (state_reg == iue_pkg::ST_SCAN && found_reg)
        begin
            kept_adv = kept_reg | j_bit;
        end
        if (state_reg == iue_pkg::ST_PICK && mask_reg[j_reg] && !started_reg)
        begin
            kept_adv = j_bit;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iue_pkg::ST_CLEAR:
            begin
                if (addr_reg == iue_pkg::ROW_CNT_W'(iue_pkg::MAX_TRANS - 1))
                begin
                    state_next = iue_pkg::ST_IDLE;
                end
            end
            iue_pkg::ST_IDLE:
            begin
                if (accept && request.cmd == iue_pkg::CMD_EVAL)
                begin
                    state_next = request.prune_enable ? iue_pkg::ST_PICK : iue_pkg::ST_SUM;
                end
            end
            iue_pkg::ST_PICK:
            begin
                if (pick_to_scan)
                begin
                    state_next = iue_pkg::ST_SCAN;
                end
                else if (last_item)
                begin
                    state_next = iue_pkg::ST_SUM;
                end
            end
            iue_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = last_item ? iue_pkg::ST_SUM : iue_pkg::ST_PICK;
                end
            end
            iue_pkg::ST_SUM:
            begin
                if (sum_end)
                begin
                    state_next = iue_pkg::ST_DONE;
                end
            end
            iue_pkg::ST_DONE:
            begin
                state_next = iue_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = iue_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mask_next     = mask_reg;
        kept_next     = kept_reg;
        need_next     = need_reg;
        started_next  = started_reg;
        j_next        = j_reg;
        addr_next     = addr_reg;
        rows_next     = rows_reg;
        found_next    = found_reg;
        total_next    = total_reg;
        sat_next      = sat_reg;
        rd_valid_next = issue;
        if (issue)
        begin
            addr_next = addr_reg + iue_pkg::ROW_CNT_W'(1);
        end
        case (state_reg)
            iue_pkg::ST_CLEAR:
            begin
                addr_next = addr_reg + iue_pkg::ROW_CNT_W'(1);
            end
            iue_pkg::ST_IDLE:
            begin
                mask_next    = request.candidate_mask & iue_pkg::item_mask(n_items);
                kept_next    = '0;
                started_next = 1'b0;
                j_next       = '0;
                addr_next    = '0;
                total_next   = '0;
                sat_next     = 1'b0;
                rows_next    = (transactions_in_use > iue_pkg::ROW_CNT_W'(iue_pkg::MAX_TRANS))
                               ? iue_pkg::ROW_CNT_W'(iue_pkg::MAX_TRANS)
                               : transactions_in_use;
            end
            iue_pkg::ST_PICK:
            begin
                kept_next = kept_adv;
                if (mask_reg[j_reg])
                begin
                    started_next = 1'b1;
                end
                if (pick_to_scan)
                begin
                    need_next  = kept_reg | j_bit;
                    addr_next  = '0;
                    found_next = 1'b0;
                end
                else if (last_item)
                begin
                    mask_next = kept_adv;
                    addr_next = '0;
                end
                else
                begin
                    j_next = j_reg + iue_pkg::ITEM_IDX_W'(1);
                end
            end
            iue_pkg::ST_SCAN:
            begin
                if (rd_valid_reg && ((rd_pres & need_reg) == need_reg))
                begin
                    found_next = 1'b1;
                end
                if (scan_end)
                begin
                    kept_next = kept_adv;
                    if (last_item)
                    begin
                        mask_next = kept_adv;
                        addr_next = '0;
                    end
                    else
                    begin
                        j_next = j_reg + iue_pkg::ITEM_IDX_W'(1);
                    end
                end
            end
            iue_pkg::ST_SUM:
            begin
                if (add_stat.valid)
                begin
                    if (acc[iue_pkg::SUM_W])
                    begin
                        total_next = '1;
                        sat_next   = 1'b1;
                    end
                    else
                    begin
                        total_next = acc[iue_pkg::SUM_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= iue_pkg::ST_CLEAR;
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg    <= mask_next;
        kept_reg    <= kept_next;
        need_reg    <= need_next;
        started_reg <= started_next;
        j_reg       <= j_next;
        rows_reg    <= rows_next;
        found_reg   <= found_next;
        total_reg   <= total_next;
        sat_reg     <= sat_next;
    end

    // table ports and result
    always_comb
    begin
        wr         = '0;
        rd.en      = issue;
        rd.addr    = addr_reg[iue_pkg::TRANS_IDX_W-1:0];
        if (state_reg == iue_pkg::ST_CLEAR)
        begin
            wr.en     = 1'b1;
            wr.addr   = addr_reg[iue_pkg::TRANS_IDX_W-1:0];
            wr.bit_en = '1;
        end
        else if (accept && request.cmd == iue_pkg::CMD_LOAD)
        begin
            wr.en      = 1'b1;
            wr.addr    = request.trans_index;
            wr.bit_en  = iue_pkg::MAX_ITEMS'(1) << request.item_index;
            wr.pres    = {iue_pkg::MAX_ITEMS{request.present}};
            wr.util_en = 1'b1;
            wr.lane    = request.item_index;
            wr.util    = request.item_utility;
        end
        busy                   = (state_reg != iue_pkg::ST_IDLE);
        done                   = (state_reg == iue_pkg::ST_DONE);
        rd_valid               = rd_valid_reg && (state_reg == iue_pkg::ST_SUM);
        sum_mask               = mask_reg;
        result.kept_mask       = mask_reg;
        result.utility_sum     = total_reg;
        result.is_high_utility = (total_reg >= utility_floor);
        result.saturated       = sat_reg;
    end

endmodule

// ===== rtl/itemset_utility_evaluator.sv =====
// load: loads are taken back to back with busy low
// evaluate: one presence/utility row read per cycle (no reads for an empty mask)
// feeds a two-stage adder tree whose row sums are added into the result
// pruning adds an item pick step for each item position, one row scan per test
// the result is held one cycle under done, the receiver cannot stall
// after reset the presence rows are cleared in a pass over all 1024 rows with busy high
`include "itemset_utility_evaluator_defines.svh"

module itemset_utility_evaluator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  iue_pkg::request_t   request,
    output logic                done,
    output iue_pkg::result_t    result,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    logic [iue_pkg::ITEM_CNT_W-1:0] items_in_use_reg;
    logic [iue_pkg::ROW_CNT_W-1:0]  transactions_in_use_reg;
    logic [31:0]                    utility_floor_reg;

    iue_pkg::tbl_wr_t              wr;
    iue_pkg::tbl_rd_t              rd;
    iue_pkg::add_stat_t            add_stat;
    logic [iue_pkg::MAX_ITEMS-1:0] rd_pres;
    logic [iue_pkg::UTIL_BITS-1:0] rd_util [iue_pkg::MAX_ITEMS];
    logic                          rd_valid;
    logic [iue_pkg::MAX_ITEMS-1:0] sum_mask;
    logic [iue_pkg::ROWSUM_W-1:0]  row_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_in_use_reg        <= iue_pkg::ITEM_CNT_W'(32);
            transactions_in_use_reg <= iue_pkg::ROW_CNT_W'(1024);
            utility_floor_reg       <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                iue_pkg::CFG_ITEMS: items_in_use_reg <= cfg_data[iue_pkg::ITEM_CNT_W-1:0];
                iue_pkg::CFG_TRANS: transactions_in_use_reg <= cfg_data[iue_pkg::ROW_CNT_W-1:0];
                iue_pkg::CFG_MIN:   utility_floor_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    iue_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_pres (rd_pres),
        .rd_util (rd_util)
    );

    iue_adder u_adder (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid),
        .mask     (sum_mask),
        .pres     (rd_pres),
        .util     (rd_util),
        .stat     (add_stat),
        .row_sum  (row_sum)
    );

    iue_ctrl u_ctrl (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .request             (request),
        .items_in_use        (items_in_use_reg),
        .transactions_in_use (transactions_in_use_reg),
        .utility_floor       (utility_floor_reg),
        .rd_pres             (rd_pres),
        .add_stat            (add_stat),
        .row_sum             (row_sum),
        .wr                  (wr),
        .rd                  (rd),
        .rd_valid            (rd_valid),
        .sum_mask            (sum_mask),
        .busy                (busy),
        .done                (done),
        .result              (result)
    );

    `IUE_ASSERT_SAME(a_done_busy, done, busy)
    `IUE_ASSERT_NEXT(a_done_single, done, !done)
    `IUE_ASSERT_NEXT(a_eval_busy, start && !busy && request.cmd == iue_pkg::CMD_EVAL, busy)
    `IUE_ASSERT_SAME(a_sat_max, done && result.saturated, result.utility_sum == 32'hFFFFFFFF)

endmodule
